### rtl/cpve_pkg.sv
// cpve_pkg: shared constants for the coons patch vertex evaluator
// no dependencies; used by the channel interfaces and all rtl modules but cpve_div
`timescale 1ns / 1ps

package cpve_pkg;

  // default sizing
  localparam int DEF_COORD_WIDTH = 24;
  localparam int DEF_MAX_SEGS    = 64;

  // field widths
  localparam int NUM_PTS    = 12;
  localparam int SEG_W      = 7;
  localparam int IDX_W      = 4;
  localparam int TEX_W      = 16;
  localparam int TEXC_W     = 24;
  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // boundary curve corner points, clockwise from top left
  localparam int CORNER_TL = 0;
  localparam int CORNER_TR = 3;
  localparam int CORNER_BR = 6;
  localparam int CORNER_BL = 9;
  localparam int PTS_PER_CURVE = 3;

  // full-scale colour byte
  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEGS_U     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGS_V     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd3;

  // register reset values
  localparam logic [SEG_W-1:0] SEGS_RESET = 7'd10;
  localparam logic [TEX_W-1:0] TEX_RESET  = 16'd1;

  // request modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

endpackage

### rtl/cpve_in_if.sv
// cpve_in_if: request channel (load a control point or evaluate a vertex)
// depends on cpve_pkg for field widths
`timescale 1ns / 1ps

interface cpve_in_if import cpve_pkg::*; #(
  parameter int CW = DEF_COORD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [IDX_W-1:0]     point_index;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic [SEG_W-1:0]     grid_col;
  logic [SEG_W-1:0]     grid_row;

  modport source (
    output valid, mode, point_index, point_x, point_y, grid_col, grid_row,
    input  ready
  );
  modport sink (
    input  valid, mode, point_index, point_x, point_y, grid_col, grid_row,
    output ready
  );
endinterface

### rtl/cpve_out_if.sv
// cpve_out_if: vertex result channel
// depends on cpve_pkg for field widths
`timescale 1ns / 1ps

interface cpve_out_if import cpve_pkg::*; #(
  parameter int CW = DEF_COORD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vert_x;
  logic signed [CW-1:0] vert_y;
  logic [TEXC_W-1:0]    tex_s;
  logic [TEXC_W-1:0]    tex_t;
  logic [COLOR_W-1:0]   color_red;
  logic [COLOR_W-1:0]   color_green;
  logic                 out_of_range;

  modport source (
    output valid, vert_x, vert_y, tex_s, tex_t, color_red, color_green, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, vert_x, vert_y, tex_s, tex_t, color_red, color_green, out_of_range,
    output ready
  );
endinterface

### rtl/cpve_div.sv
// cpve_div: pipelined unsigned restoring divider, one quotient bit per stage
// standalone; requires num < den * 2**QW; each stage register advances only while en is high
`timescale 1ns / 1ps

module cpve_div #(
  parameter int DW = 16,
  parameter int QW = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);
  localparam int NW = DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [NW-1:0] dsh;
    logic          ge;

    // stage inputs
    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // trial subtract of the shifted divisor
    assign dsh = NW'(den_in) << SH;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_in - dsh) : rem_in;
        den_r[k] <= den_in;
        quo_r[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

### rtl/coons_patch_vertex_eval.sv
// coons_patch_vertex_eval: coons patch vertex evaluator, top level
// depends on cpve_pkg, cpve_in_if, cpve_out_if and cpve_div
`timescale 1ns / 1ps

// Takes one request per clock unless stalled and returns one vertex per
// evaluate request (a load request writes a control point and returns
// nothing). The pipeline is fully pipelined: throughput is one request per
// cycle unless stalled, and the path from request to result runs through
// the two bit-per-stage divider chains (boundary curve normalization, then
// the blended sheet and texture and colour scaling). Loads take effect in
// request order for later evaluates. Results stall the whole pipeline only
// when the output register is full and not taken. The user must write
// registers only while no request is in flight; the block itself does not
// enforce this.

module coons_patch_vertex_eval import cpve_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int MAX_SEGS    = DEF_MAX_SEGS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cpve_in_if.sink               req_in,
  cpve_out_if.source            res_out
);
  localparam int CW   = COORD_WIDTH;
  localparam int SW   = SEG_W;
  localparam int WW   = 2 * SW;
  localparam int N3_W = 3 * SW;
  localparam int PR_W = CW + N3_W + 1;
  localparam int DW1  = N3_W + 1;
  localparam int QW1  = CW;
  localparam int N1_W = DW1 + QW1;
  localparam int GP_W = CW + WW + 1;
  localparam int DW2  = WW + 1;
  localparam int QW2  = (CW + 2 > TEXC_W) ? CW + 2 : TEXC_W;
  localparam int N2_W = DW2 + QW2;
  localparam int TP_W = SW + TEX_W;

  localparam logic [N1_W-1:0]        CURVE_BIAS_SH = N1_W'(CW);
  localparam logic signed [QW2:0]    SHEET_BIAS = (QW2+1)'(1) << (CW + 1);
  localparam logic signed [QW2:0]    SAT_HI = (QW2+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [QW2:0]    SAT_LO = ~SAT_HI;

  // carried along with each evaluate request
  typedef struct packed {
    logic                   oor;
    logic [SW-1:0]          c;
    logic [SW-1:0]          r;
    logic [SW-1:0]          nu;
    logic [SW-1:0]          nv;
    logic [7:0][WW-1:0]     w;
    logic [WW-1:0]          den2;
    logic [3:0][CW-1:0]     cx;
    logic [3:0][CW-1:0]     cy;
  } sb1_t;

  logic adv;

  // configuration registers
  logic [SW-1:0]    segs_u, segs_v;
  logic [TEX_W-1:0] tex_width, tex_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      segs_u     <= SEGS_RESET;
      segs_v     <= SEGS_RESET;
      tex_width  <= TEX_RESET;
      tex_height <= TEX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEGS_U:     segs_u     <= cfg_data[SW-1:0];
        REG_SEGS_V:     segs_v     <= cfg_data[SW-1:0];
        REG_TEX_WIDTH:  tex_width  <= cfg_data[TEX_W-1:0];
        REG_TEX_HEIGHT: tex_height <= cfg_data[TEX_W-1:0];
        default:        ;
      endcase
    end
  end

  // segment counts saturated to the grid limit
  logic [SW-1:0] nu_w, nv_w;
  assign nu_w = (int'(segs_u) > MAX_SEGS) ? SW'(MAX_SEGS) : segs_u;
  assign nv_w = (int'(segs_v) > MAX_SEGS) ? SW'(MAX_SEGS) : segs_v;

  // global advance: output register empty or being taken
  assign adv          = !res_out.valid || res_out.ready;
  assign req_in.ready = adv;

  // stage a: request capture
  logic                 a_v, a_mode;
  logic [IDX_W-1:0]     a_idx;
  logic signed [CW-1:0] a_px, a_py;
  logic [SW-1:0]        a_c, a_r;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= req_in.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mode <= req_in.mode;
      a_idx  <= req_in.point_index;
      a_px   <= req_in.point_x;
      a_py   <= req_in.point_y;
      a_c    <= req_in.grid_col;
      a_r    <= req_in.grid_row;
    end
  end

  // stage b: complements, squares and sheet weights
  logic                 b_v, b_mode;
  logic [IDX_W-1:0]     b_idx;
  logic signed [CW-1:0] b_px, b_py;
  logic [SW-1:0]        b_au, b_av;
  logic [WW-1:0]        b_au2, b_c2, b_av2, b_r2, b_nu2, b_nv2;
  sb1_t                 b_sb;
  logic [SW-1:0]        au_w, av_w;

  assign au_w = nu_w - a_c;
  assign av_w = nv_w - a_r;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mode    <= a_mode;
      b_idx     <= a_idx;
      b_px      <= a_px;
      b_py      <= a_py;
      b_au      <= au_w;
      b_av      <= av_w;
      b_au2     <= WW'(au_w) * WW'(au_w);
      b_c2      <= WW'(a_c) * WW'(a_c);
      b_av2     <= WW'(av_w) * WW'(av_w);
      b_r2      <= WW'(a_r) * WW'(a_r);
      b_nu2     <= WW'(nu_w) * WW'(nu_w);
      b_nv2     <= WW'(nv_w) * WW'(nv_w);
      b_sb.oor  <= (nu_w == '0) || (nv_w == '0) || (a_c > nu_w) || (a_r > nv_w);
      b_sb.c    <= a_c;
      b_sb.r    <= a_r;
      b_sb.nu   <= nu_w;
      b_sb.nv   <= nv_w;
      b_sb.w[0] <= WW'(av_w) * WW'(nu_w);
      b_sb.w[1] <= WW'(a_c) * WW'(nv_w);
      b_sb.w[2] <= WW'(a_r) * WW'(nu_w);
      b_sb.w[3] <= WW'(au_w) * WW'(nv_w);
      b_sb.w[4] <= WW'(au_w) * WW'(av_w);
      b_sb.w[5] <= WW'(a_c) * WW'(av_w);
      b_sb.w[6] <= WW'(au_w) * WW'(a_r);
      b_sb.w[7] <= WW'(a_c) * WW'(a_r);
      b_sb.den2 <= WW'(nu_w) * WW'(nv_w);
      b_sb.cx   <= '0;
      b_sb.cy   <= '0;
    end
  end

  // stage c: bernstein coefficients and curve denominators
  logic                 c_v, c_mode;
  logic [IDX_W-1:0]     c_idx;
  logic signed [CW-1:0] c_px, c_py;
  logic [N3_W-1:0]      c_ku [4];
  logic [N3_W-1:0]      c_kv [4];
  logic [N3_W-1:0]      c_nu3, c_nv3;
  sb1_t                 c_sb;

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (adv) c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mode  <= b_mode;
      c_idx   <= b_idx;
      c_px    <= b_px;
      c_py    <= b_py;
      c_ku[0] <= N3_W'(b_au2) * N3_W'(b_au);
      c_ku[1] <= N3_W'(b_au2) * N3_W'(b_sb.c) * N3_W'(PTS_PER_CURVE);
      c_ku[2] <= N3_W'(b_c2) * N3_W'(b_au) * N3_W'(PTS_PER_CURVE);
      c_ku[3] <= N3_W'(b_c2) * N3_W'(b_sb.c);
      c_kv[0] <= N3_W'(b_av2) * N3_W'(b_av);
      c_kv[1] <= N3_W'(b_av2) * N3_W'(b_sb.r) * N3_W'(PTS_PER_CURVE);
      c_kv[2] <= N3_W'(b_r2) * N3_W'(b_av) * N3_W'(PTS_PER_CURVE);
      c_kv[3] <= N3_W'(b_r2) * N3_W'(b_sb.r);
      c_nu3   <= N3_W'(b_nu2) * N3_W'(b_sb.nu);
      c_nv3   <= N3_W'(b_nv2) * N3_W'(b_sb.nv);
      c_sb    <= b_sb;
    end
  end

  // control point store, written as a load request leaves stage c
  logic signed [CW-1:0] pts_x [NUM_PTS];
  logic signed [CW-1:0] pts_y [NUM_PTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PTS; k++) begin
        pts_x[k] <= '0;
        pts_y[k] <= '0;
      end
    end else if (adv && c_v && (c_mode == MODE_LOAD) && (int'(c_idx) < NUM_PTS)) begin
      pts_x[c_idx] <= c_px;
      pts_y[c_idx] <= c_py;
    end
  end

  // coefficient per curve and term: top and right run forward, bottom and
  // left run with the reversed parameter
  logic [N3_W-1:0] coef [4][4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        case (k)
          0:       coef[k][j] = c_ku[j];
          1:       coef[k][j] = c_kv[j];
          2:       coef[k][j] = c_ku[3-j];
          default: coef[k][j] = c_kv[3-j];
        endcase
      end
    end
  end

  // side data with the corner points picked up
  sb1_t d_sb_next;

  always_comb begin
    d_sb_next       = c_sb;
    d_sb_next.cx[0] = pts_x[CORNER_TL];
    d_sb_next.cx[1] = pts_x[CORNER_TR];
    d_sb_next.cx[2] = pts_x[CORNER_BL];
    d_sb_next.cx[3] = pts_x[CORNER_BR];
    d_sb_next.cy[0] = pts_y[CORNER_TL];
    d_sb_next.cy[1] = pts_y[CORNER_TR];
    d_sb_next.cy[2] = pts_y[CORNER_BL];
    d_sb_next.cy[3] = pts_y[CORNER_BR];
  end

  // stage d: coefficient times control point
  logic                   d_v;
  logic signed [PR_W-1:0] d_px [4][4];
  logic signed [PR_W-1:0] d_py [4][4];
  logic [N3_W-1:0]        d_nu3, d_nv3;
  sb1_t                   d_sb;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (adv) d_v <= c_v && (c_mode == MODE_EVAL);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          d_px[k][j] <= $signed({1'b0, coef[k][j]})
                        * pts_x[(PTS_PER_CURVE * k + j) % NUM_PTS];
          d_py[k][j] <= $signed({1'b0, coef[k][j]})
                        * pts_y[(PTS_PER_CURVE * k + j) % NUM_PTS];
        end
      end
      d_nu3 <= c_nu3;
      d_nv3 <= c_nv3;
      d_sb  <= d_sb_next;
    end
  end

  // stage e: curve numerators
  logic            e_v;
  logic [N1_W-1:0] e_sx [4];
  logic [N1_W-1:0] e_sy [4];
  logic [N3_W-1:0] e_nu3, e_nv3;
  sb1_t            e_sb;

  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (adv) e_v <= d_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        e_sx[k] <= N1_W'(d_px[k][0]) + N1_W'(d_px[k][1])
                 + N1_W'(d_px[k][2]) + N1_W'(d_px[k][3]);
        e_sy[k] <= N1_W'(d_py[k][0]) + N1_W'(d_py[k][1])
                 + N1_W'(d_py[k][2]) + N1_W'(d_py[k][3]);
      end
      e_nu3 <= d_nu3;
      e_nv3 <= d_nv3;
      e_sb  <= d_sb;
    end
  end

  // stage f: rounding and offset so the divider sees a positive dividend
  logic            f_v;
  logic [N1_W-1:0] f_nx [4];
  logic [N1_W-1:0] f_ny [4];
  logic [DW1-1:0]  f_du, f_dv;
  sb1_t            f_sb;

  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (adv) f_v <= e_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        if (k == 0 || k == 2) begin
          f_nx[k] <= (e_sx[k] << 1) + N1_W'(e_nu3) + (N1_W'(e_nu3) << CURVE_BIAS_SH);
          f_ny[k] <= (e_sy[k] << 1) + N1_W'(e_nu3) + (N1_W'(e_nu3) << CURVE_BIAS_SH);
        end else begin
          f_nx[k] <= (e_sx[k] << 1) + N1_W'(e_nv3) + (N1_W'(e_nv3) << CURVE_BIAS_SH);
          f_ny[k] <= (e_sy[k] << 1) + N1_W'(e_nv3) + (N1_W'(e_nv3) << CURVE_BIAS_SH);
        end
      end
      f_du <= {e_nu3, 1'b0};
      f_dv <= {e_nv3, 1'b0};
      f_sb <= e_sb;
    end
  end

  // curve dividers
  logic [QW1-1:0] q1x [4];
  logic [QW1-1:0] q1y [4];

  for (genvar k = 0; k < 4; k++) begin : g_div1
    logic [DW1-1:0] dsel;
    assign dsel = (k == 0 || k == 2) ? f_du : f_dv;

    cpve_div #(.DW(DW1), .QW(QW1)) u_div_x (
      .clk (clk), .en (adv), .num (f_nx[k]), .den (dsel), .quo (q1x[k])
    );
    cpve_div #(.DW(DW1), .QW(QW1)) u_div_y (
      .clk (clk), .en (adv), .num (f_ny[k]), .den (dsel), .quo (q1y[k])
    );
  end

  // side data alongside the curve dividers
  logic [QW1-1:0] sb1_v;
  sb1_t           sb1_line [QW1];

  always_ff @(posedge clk) begin
    if (rst) sb1_v <= '0;
    else if (adv) sb1_v <= {sb1_v[QW1-2:0], f_v};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1_line[0] <= f_sb;
      for (int k = 1; k < QW1; k++) sb1_line[k] <= sb1_line[k-1];
    end
  end

  sb1_t                 sb1o;
  logic signed [CW-1:0] curve_x [4];
  logic signed [CW-1:0] curve_y [4];

  assign sb1o = sb1_line[QW1-1];

  // remove the curve offset by flipping the top bit
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      curve_x[k] = $signed({~q1x[k][CW-1], q1x[k][CW-2:0]});
      curve_y[k] = $signed({~q1y[k][CW-1], q1y[k][CW-2:0]});
    end
  end

  // stage g: sheet weight products and texture products
  logic                   g_v, g_oor;
  logic signed [GP_W-1:0] g_px [8];
  logic signed [GP_W-1:0] g_py [8];
  logic [TP_W-1:0]        g_ts, g_tt;
  logic [SW-1:0]          g_c, g_r, g_nu, g_nv;
  logic [WW-1:0]          g_den2;

  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else if (adv) g_v <= sb1_v[QW1-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        g_px[k]   <= $signed({1'b0, sb1o.w[k]}) * curve_x[k];
        g_py[k]   <= $signed({1'b0, sb1o.w[k]}) * curve_y[k];
        g_px[k+4] <= $signed({1'b0, sb1o.w[k+4]}) * $signed(sb1o.cx[k]);
        g_py[k+4] <= $signed({1'b0, sb1o.w[k+4]}) * $signed(sb1o.cy[k]);
      end
      g_ts   <= TP_W'(sb1o.c) * TP_W'(tex_width);
      g_tt   <= TP_W'(sb1o.r) * TP_W'(tex_height);
      g_oor  <= sb1o.oor;
      g_c    <= sb1o.c;
      g_r    <= sb1o.r;
      g_nu   <= sb1o.nu;
      g_nv   <= sb1o.nv;
      g_den2 <= sb1o.den2;
    end
  end

  // stage h: pairwise sums, texture and colour dividends
  logic            h_v, h_oor;
  logic [N2_W-1:0] h_sx [4];
  logic [N2_W-1:0] h_sy [4];
  logic [N2_W-1:0] h_ns, h_nt, h_nr, h_ng;
  logic [SW-1:0]   h_nu, h_nv;
  logic [WW-1:0]   h_den2;

  always_ff @(posedge clk) begin
    if (rst) h_v <= 1'b0;
    else if (adv) h_v <= g_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        h_sx[k] <= N2_W'(g_px[2*k]) + N2_W'(g_px[2*k+1]);
        h_sy[k] <= N2_W'(g_py[2*k]) + N2_W'(g_py[2*k+1]);
      end
      h_ns   <= (N2_W'(g_ts) << 9) + N2_W'(g_nu);
      h_nt   <= (N2_W'(g_tt) << 9) + N2_W'(g_nv);
      h_nr   <= N2_W'(g_c) * (N2_W'(COLOR_MAX) << 1) + N2_W'(g_nu);
      h_ng   <= N2_W'(g_r) * (N2_W'(COLOR_MAX) << 1) + N2_W'(g_nv);
      h_oor  <= g_oor;
      h_nu   <= g_nu;
      h_nv   <= g_nv;
      h_den2 <= g_den2;
    end
  end

  // stage i: boundary terms less corner blend
  logic            i_v, i_oor;
  logic [N2_W-1:0] i_sx, i_sy;
  logic [N2_W-1:0] i_ns, i_nt, i_nr, i_ng;
  logic [SW-1:0]   i_nu, i_nv;
  logic [WW-1:0]   i_den2;

  always_ff @(posedge clk) begin
    if (rst) i_v <= 1'b0;
    else if (adv) i_v <= h_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_sx   <= h_sx[0] + h_sx[1] - h_sx[2] - h_sx[3];
      i_sy   <= h_sy[0] + h_sy[1] - h_sy[2] - h_sy[3];
      i_ns   <= h_ns;
      i_nt   <= h_nt;
      i_nr   <= h_nr;
      i_ng   <= h_ng;
      i_oor  <= h_oor;
      i_nu   <= h_nu;
      i_nv   <= h_nv;
      i_den2 <= h_den2;
    end
  end

  // stage j: sheet rounding and offset, divisors
  logic            j_v, j_oor;
  logic [N2_W-1:0] j_nx, j_ny, j_ns, j_nt, j_nr, j_ng;
  logic [DW2-1:0]  j_dxy, j_du, j_dv;

  always_ff @(posedge clk) begin
    if (rst) j_v <= 1'b0;
    else if (adv) j_v <= i_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_nx  <= (i_sx << 1) + N2_W'(i_den2) + (N2_W'({i_den2, 1'b0}) << (CW + 1));
      j_ny  <= (i_sy << 1) + N2_W'(i_den2) + (N2_W'({i_den2, 1'b0}) << (CW + 1));
      j_ns  <= i_ns;
      j_nt  <= i_nt;
      j_nr  <= i_nr;
      j_ng  <= i_ng;
      j_dxy <= {i_den2, 1'b0};
      j_du  <= DW2'({i_nu, 1'b0});
      j_dv  <= DW2'({i_nv, 1'b0});
      j_oor <= i_oor;
    end
  end

  // sheet, texture and colour dividers
  logic [QW2-1:0] q2x, q2y, q2s, q2t, q2r, q2g;

  cpve_div #(.DW(DW2), .QW(QW2)) u_div_sx (
    .clk (clk), .en (adv), .num (j_nx), .den (j_dxy), .quo (q2x)
  );
  cpve_div #(.DW(DW2), .QW(QW2)) u_div_sy (
    .clk (clk), .en (adv), .num (j_ny), .den (j_dxy), .quo (q2y)
  );
  cpve_div #(.DW(DW2), .QW(QW2)) u_div_ts (
    .clk (clk), .en (adv), .num (j_ns), .den (j_du), .quo (q2s)
  );
  cpve_div #(.DW(DW2), .QW(QW2)) u_div_tt (
    .clk (clk), .en (adv), .num (j_nt), .den (j_dv), .quo (q2t)
  );
  cpve_div #(.DW(DW2), .QW(QW2)) u_div_cr (
    .clk (clk), .en (adv), .num (j_nr), .den (j_du), .quo (q2r)
  );
  cpve_div #(.DW(DW2), .QW(QW2)) u_div_cg (
    .clk (clk), .en (adv), .num (j_ng), .den (j_dv), .quo (q2g)
  );

  // valid and range flag alongside the second dividers
  logic [QW2-1:0] sb2_v, sb2_oor;

  always_ff @(posedge clk) begin
    if (rst) sb2_v <= '0;
    else if (adv) sb2_v <= {sb2_v[QW2-2:0], j_v};
  end

  always_ff @(posedge clk) begin
    if (adv) sb2_oor <= {sb2_oor[QW2-2:0], j_oor};
  end

  // remove sheet offset and saturate
  logic signed [QW2:0] sx_w, sy_w;
  logic signed [CW-1:0] vx_w, vy_w;
  logic                 oor_o;

  assign sx_w  = $signed({1'b0, q2x}) - SHEET_BIAS;
  assign sy_w  = $signed({1'b0, q2y}) - SHEET_BIAS;
  assign vx_w  = (sx_w > SAT_HI) ? CW'(SAT_HI) : (sx_w < SAT_LO) ? CW'(SAT_LO) : CW'(sx_w);
  assign vy_w  = (sy_w > SAT_HI) ? CW'(SAT_HI) : (sy_w < SAT_LO) ? CW'(SAT_LO) : CW'(sy_w);
  assign oor_o = sb2_oor[QW2-1];

  // output register
  always_ff @(posedge clk) begin
    if (rst) res_out.valid <= 1'b0;
    else if (adv) res_out.valid <= sb2_v[QW2-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_out.out_of_range <= oor_o;
      res_out.vert_x       <= oor_o ? '0 : vx_w;
      res_out.vert_y       <= oor_o ? '0 : vy_w;
      res_out.tex_s        <= oor_o ? '0 : q2s[TEXC_W-1:0];
      res_out.tex_t        <= oor_o ? '0 : q2t[TEXC_W-1:0];
      res_out.color_red    <= oor_o ? '0 : q2r[COLOR_W-1:0];
      res_out.color_green  <= oor_o ? '0 : q2g[COLOR_W-1:0];
    end
  end

endmodule

### test/vertex_checker.sv
// vertex_checker: watches the request, result and register ports of the
// coons patch vertex evaluator, predicts each vertex and compares it
// depends on cpve_pkg, cpve_in_if and cpve_out_if
`timescale 1ns / 1ps

module vertex_checker import cpve_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cpve_in_if                    req,
  cpve_out_if                   res,
  output int                    pending,
  output int                    errors
);

  localparam int CW = DEF_COORD_WIDTH;

  typedef struct {
    logic [CW-1:0]      vx;
    logic [CW-1:0]      vy;
    logic [TEXC_W-1:0]  s;
    logic [TEXC_W-1:0]  t;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic               oor;
  } vertex_t;

  longint  pt_x [NUM_PTS];
  longint  pt_y [NUM_PTS];
  longint  nu_reg, nv_reg, tw_reg, th_reg;
  vertex_t vertex_q [$];

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint round_quot(longint num, longint den);
    return floor_quot(2 * num + den, 2 * den);
  endfunction

  // one rounded sample of the cubic starting at point base, t = i/n
  function automatic longint bezier_at(input longint p[NUM_PTS], int base,
                                       longint i, longint n);
    longint a, num;
    a = n - i;
    num = a * a * a * p[base % NUM_PTS] + 3 * a * a * i * p[(base + 1) % NUM_PTS]
        + 3 * a * i * i * p[(base + 2) % NUM_PTS] + i * i * i * p[(base + 3) % NUM_PTS];
    return round_quot(num, n * n * n);
  endfunction

  // blended coons sheet for one coordinate, saturated to CW bits
  function automatic logic [CW-1:0] coons_coord(input longint p[NUM_PTS], longint c,
                                                longint r, longint nu, longint nv);
    longint num, v, hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    num = (nv - r) * nu * bezier_at(p, CORNER_TL, c, nu)
        + c * nv * bezier_at(p, CORNER_TR, r, nv)
        + r * nu * bezier_at(p, CORNER_BR, nu - c, nu)
        + (nu - c) * nv * bezier_at(p, CORNER_BL, nv - r, nv);
    num -= (nu - c) * (nv - r) * p[CORNER_TL] + c * (nv - r) * p[CORNER_TR]
         + (nu - c) * r * p[CORNER_BL] + c * r * p[CORNER_BR];
    v = round_quot(num, nu * nv);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic vertex_t predict_vertex(longint c, longint r);
    vertex_t e;
    longint  nu, nv;
    e = '{default: '0};
    nu = (nu_reg > DEF_MAX_SEGS) ? DEF_MAX_SEGS : nu_reg;
    nv = (nv_reg > DEF_MAX_SEGS) ? DEF_MAX_SEGS : nv_reg;
    if (nu == 0 || nv == 0 || c > nu || r > nv) begin
      e.oor = 1'b1;
      return e;
    end
    e.vx    = coons_coord(pt_x, c, r, nu, nv);
    e.vy    = coons_coord(pt_y, c, r, nu, nv);
    e.s     = TEXC_W'(round_quot(c * tw_reg * 256, nu));
    e.t     = TEXC_W'(round_quot(r * th_reg * 256, nv));
    e.red   = COLOR_W'(round_quot(c * 255, nu));
    e.green = COLOR_W'(round_quot(r * 255, nv));
    return e;
  endfunction

  assign pending = vertex_q.size();

  always @(posedge clk) begin
    vertex_t e;
    if (rst) begin
      for (int k = 0; k < NUM_PTS; k++) begin
        pt_x[k] = 0;
        pt_y[k] = 0;
      end
      nu_reg = SEGS_RESET;
      nv_reg = SEGS_RESET;
      tw_reg = TEX_RESET;
      th_reg = TEX_RESET;
      vertex_q.delete();
      errors <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SEGS_U:     nu_reg = cfg_data[SEG_W-1:0];
          REG_SEGS_V:     nv_reg = cfg_data[SEG_W-1:0];
          REG_TEX_WIDTH:  tw_reg = cfg_data[TEX_W-1:0];
          REG_TEX_HEIGHT: th_reg = cfg_data[TEX_W-1:0];
          default: ;
        endcase
      end
      // accepted request
      if (req.valid && req.ready) begin
        if (req.mode == MODE_LOAD) begin
          if (req.point_index < NUM_PTS) begin
            pt_x[req.point_index] = longint'(req.point_x);
            pt_y[req.point_index] = longint'(req.point_y);
          end
        end else begin
          vertex_q.push_back(predict_vertex(req.grid_col, req.grid_row));
        end
      end
      // accepted result
      if (res.valid && res.ready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex result with no request outstanding");
          errors <= errors + 1;
        end else begin
          e = vertex_q.pop_front();
          if (res.vert_x !== e.vx || res.vert_y !== e.vy || res.tex_s !== e.s ||
              res.tex_t !== e.t || res.color_red !== e.red ||
              res.color_green !== e.green || res.out_of_range !== e.oor) begin
            if (res.vert_x !== e.vx)
              $error("vert_x expected %h got %h", e.vx, res.vert_x);
            if (res.vert_y !== e.vy)
              $error("vert_y expected %h got %h", e.vy, res.vert_y);
            if (res.tex_s !== e.s)
              $error("tex_s expected %h got %h", e.s, res.tex_s);
            if (res.tex_t !== e.t)
              $error("tex_t expected %h got %h", e.t, res.tex_t);
            if (res.color_red !== e.red)
              $error("color_red expected %h got %h", e.red, res.color_red);
            if (res.color_green !== e.green)
              $error("color_green expected %h got %h", e.green, res.color_green);
            if (res.out_of_range !== e.oor)
              $error("out_of_range expected %b got %b", e.oor, res.out_of_range);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

### test/tb.sv
// tb: stimulus and verdict for the coons patch vertex evaluator
// depends on cpve_pkg, the channel interfaces, the rtl and vertex_checker
`timescale 1ns / 1ps

module tb import cpve_pkg::*;;

  localparam int CW        = DEF_COORD_WIDTH;
  localparam int DRAIN     = 100;
  localparam int IDLE_LIMIT = 20000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    errors;
  int                    nu_now, nv_now;
  bit                    calm;
  int                    hold_reqs, hold_seen, hold_left;
  int                    idle_cycles;

  cpve_in_if  req_ch ();
  cpve_out_if res_ch ();

  coons_patch_vertex_eval i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_in    (req_ch),
    .res_out   (res_ch)
  );

  vertex_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      hold_left    <= 300;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one request and wait until it is taken
  task automatic send_req(logic mode, logic [IDX_W-1:0] idx, logic [CW-1:0] x,
                          logic [CW-1:0] y, logic [SEG_W-1:0] c, logic [SEG_W-1:0] r);
    while (!calm && $urandom_range(99) < 25) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= mode;
    req_ch.point_index <= idx;
    req_ch.point_x     <= x;
    req_ch.point_y     <= y;
    req_ch.grid_col    <= c;
    req_ch.grid_row    <= r;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic load_point(logic [IDX_W-1:0] idx, logic [CW-1:0] x, logic [CW-1:0] y);
    send_req(MODE_LOAD, idx, x, y, SEG_W'($urandom), SEG_W'($urandom));
  endtask

  task automatic eval_vertex(logic [SEG_W-1:0] c, logic [SEG_W-1:0] r);
    send_req(MODE_EVAL, IDX_W'($urandom), CW'($urandom), CW'($urandom), c, r);
  endtask

  // let everything drain, then a margin for loads still in the pipe
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_mesh(int su, int sv, int tw, int th);
    write_reg(REG_SEGS_U, CFG_DATA_W'(su));
    write_reg(REG_SEGS_V, CFG_DATA_W'(sv));
    write_reg(REG_TEX_WIDTH, CFG_DATA_W'(tw));
    write_reg(REG_TEX_HEIGHT, CFG_DATA_W'(th));
    nu_now = (su > DEF_MAX_SEGS) ? DEF_MAX_SEGS : su;
    nv_now = (sv > DEF_MAX_SEGS) ? DEF_MAX_SEGS : sv;
    @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0:       return CW'($urandom);
      1:       return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return CW'($signed($urandom_range(65535)) - 32768) <<< 4;
    endcase
  endfunction

  // random mix: full boundary reloads with evaluates, stray loads, odd cells
  task automatic random_phase(int count);
    int k;
    k = 0;
    while (k < count) begin
      if ($urandom_range(99) < 8) begin
        for (int p = 0; p < NUM_PTS; p++) load_point(IDX_W'(p), rand_coord(), rand_coord());
        k += NUM_PTS;
      end else if ($urandom_range(99) < 5) begin
        load_point(IDX_W'($urandom_range(15)), rand_coord(), rand_coord());
        k++;
      end else if ($urandom_range(99) < 10) begin
        eval_vertex(SEG_W'($urandom), SEG_W'($urandom));
        k++;
      end else begin
        eval_vertex(SEG_W'($urandom_range(nu_now)), SEG_W'($urandom_range(nv_now)));
        k++;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    calm         = 1'b0;
    hold_reqs    = 0;
    nu_now       = SEGS_RESET;
    nv_now       = SEGS_RESET;
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_LOAD;
    req_ch.point_index = '0;
    req_ch.point_x     = '0;
    req_ch.point_y     = '0;
    req_ch.grid_col    = '0;
    req_ch.grid_row    = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all-zero patch, extreme points, ignored indexes, corners and range edges
    eval_vertex(5, 5);
    for (int p = 0; p < NUM_PTS; p++)
      load_point(IDX_W'(p), (p % 2) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}},
                 (p % 3) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
    load_point(12, '1, '1);
    load_point(15, '0, '1);
    eval_vertex(0, 0);
    eval_vertex(10, 10);
    eval_vertex(10, 0);
    eval_vertex(0, 10);
    eval_vertex(3, 7);
    eval_vertex(11, 0);
    eval_vertex(0, 11);
    eval_vertex(127, 127);
    drain();

    // register extremes, including zero segments and saturated segments
    set_mesh(1, 1, 0, 0);
    random_phase(120);
    drain();
    set_mesh(64, 64, 65535, 65535);
    random_phase(150);
    drain();
    set_mesh(127, 3, 300, 1);
    random_phase(120);
    drain();
    set_mesh(0, 10, 7, 9);
    random_phase(40);
    drain();
    set_mesh(6, 0, 1, 1);
    random_phase(40);
    drain();

    // long result hold-off with requests streaming in
    set_mesh(8, 12, 640, 480);
    calm = 1'b1;
    hold_reqs++;
    random_phase(200);
    calm = 1'b0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_mesh($urandom_range(1, 70), $urandom_range(1, 70),
               $urandom_range(65535), $urandom_range(65535));
      random_phase(150);
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
